// ===== design/dxt_pkg.sv =====
// dxt_pkg: shared types and constants for the texel decoder pipeline
// no dependencies; imported by every stage module and the top level
package dxt_pkg;

  // block format codes held in the format register
  localparam logic [1:0] FMT_DXT1  = 2'd0;
  localparam logic [1:0] FMT_PUNCH = 2'd1;
  localparam logic [1:0] FMT_DXT3  = 2'd2;
  localparam logic [1:0] FMT_DXT5  = 2'd3;

  // register indexes on the configuration port
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_OUT16  = 1'b1;

  // how the alpha numerator is finished in the divide stage
  localparam logic [1:0] ALPHA_DIRECT = 2'd0;
  localparam logic [1:0] ALPHA_DIV5   = 2'd1;
  localparam logic [1:0] ALPHA_DIV7   = 2'd2;

  // reciprocal multipliers, exact floor over the numerator ranges used here
  localparam logic [9:0]  RECIP3      = 10'd683;   // shift 11, numerators below 768
  localparam logic [11:0] RECIP5      = 12'd3277;  // shift 14, numerators below 1280
  localparam logic [11:0] RECIP7      = 12'd2341;  // shift 14, numerators below 1792

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // colour channel order inside the packed arrays
  localparam int CH_R = 2;
  localparam int CH_G = 1;
  localparam int CH_B = 0;

  // after unpacking: endpoints widened, codes picked for the texel
  typedef struct packed {
    logic [1:0]      code;
    logic            four;
    logic [2:0][7:0] e0;
    logic [2:0][7:0] e1;
    logic [7:0]      a0;
    logic [7:0]      a1;
    logic [2:0]      acode;
    logic [7:0]      a3;
  } unpack_t;

  // after interpolation: numerators and how to finish them
  typedef struct packed {
    logic [2:0][9:0] cnum;
    logic            div3;
    logic [10:0]     anum;
    logic [1:0]      akind;
  } interp_t;

  // after division: final 8-bit channels
  typedef struct packed {
    logic [7:0]      a;
    logic [2:0][7:0] rgb;
  } texel_t;

endpackage

// ===== design/dxt_unpack.sv =====
// dxt_unpack: first pipeline stage, endpoint expansion and code selection
// depends on dxt_pkg
module dxt_unpack
  import dxt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  block_format,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] alpha_block,
  input  logic [63:0] color_block,
  input  logic [1:0]  texel_col,
  input  logic [1:0]  texel_row,
  output logic        out_valid,
  input  logic        out_stall,
  output unpack_t     out_data
);

  logic [3:0]  tix;
  logic [15:0] c0;
  logic [15:0] c1;
  logic [31:0] cbits;
  logic [47:0] abits;
  logic [5:0]  aidx;
  logic [3:0]  nib;
  logic        adv;
  unpack_t     data_next;
  logic        valid;
  unpack_t     data;

  // texel index and field selection
  always_comb begin
    tix   = {texel_row, texel_col};
    c0    = color_block[15:0];
    c1    = color_block[31:16];
    cbits = color_block[63:32];
    abits = alpha_block[63:16];
    aidx  = 6'({tix, 1'b0}) + 6'(tix);
    nib   = alpha_block[{tix, 2'b00} +: 4];

    data_next.code     = cbits[{tix, 1'b0} +: 2];
    data_next.four     = (block_format == FMT_DXT3) || (block_format == FMT_DXT5) || (c0 > c1);
    data_next.e0[CH_R] = {c0[15:11], c0[15:13]};
    data_next.e0[CH_G] = {c0[10:5], c0[10:9]};
    data_next.e0[CH_B] = {c0[4:0], c0[4:2]};
    data_next.e1[CH_R] = {c1[15:11], c1[15:13]};
    data_next.e1[CH_G] = {c1[10:5], c1[10:9]};
    data_next.e1[CH_B] = {c1[4:0], c1[4:2]};
    data_next.a0       = alpha_block[7:0];
    data_next.a1       = alpha_block[15:8];
    data_next.acode    = abits[aidx +: 3];
    data_next.a3       = {nib, nib};
  end

  // stage register, moves whenever empty or not held downstream
  assign adv      = !valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== design/dxt_interp.sv =====
// dxt_interp: second pipeline stage, colour and alpha numerators
// depends on dxt_pkg
module dxt_interp
  import dxt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] block_format,
  input  logic       in_valid,
  output logic       in_stall,
  input  unpack_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output interp_t    out_data
);

  logic [8:0]  half;
  logic [2:0]  w0;
  logic [2:0]  w1;
  logic [10:0] wsum;
  logic        adv;
  interp_t     data_next;
  logic        valid;
  interp_t     data;

  // dxt5 weights: sevenths when a0 > a1, fifths otherwise
  always_comb begin
    if (in_data.a0 > in_data.a1) begin
      w0 = 3'(4'd8 - 4'(in_data.acode));
    end else begin
      w0 = 3'd6 - in_data.acode;
    end
    w1   = in_data.acode - 3'd1;
    wsum = (11'(w0) * 11'(in_data.a0)) + (11'(w1) * 11'(in_data.a1));
  end

  // colour selection per channel, then the alpha rule by format
  always_comb begin
    half           = 9'd0;
    data_next.div3 = in_data.four && in_data.code[1];
    for (int ch = 0; ch < 3; ch++) begin
      half = 9'(in_data.e0[ch]) + 9'(in_data.e1[ch]);
      case (in_data.code)
        2'd0: data_next.cnum[ch] = 10'(in_data.e0[ch]);
        2'd1: data_next.cnum[ch] = 10'(in_data.e1[ch]);
        2'd2: begin
          if (in_data.four) begin
            data_next.cnum[ch] = {1'b0, in_data.e0[ch], 1'b0} + 10'(in_data.e1[ch]);
          end else begin
            data_next.cnum[ch] = 10'(half[8:1]);
          end
        end
        default: begin
          if (in_data.four) begin
            data_next.cnum[ch] = 10'(in_data.e0[ch]) + {1'b0, in_data.e1[ch], 1'b0};
          end else begin
            data_next.cnum[ch] = 10'd0;
          end
        end
      endcase
    end

    // alpha rule by format
    data_next.akind = ALPHA_DIRECT;
    data_next.anum  = 11'(ALPHA_OPAQUE);
    case (block_format)
      FMT_PUNCH: begin
        if (in_data.code == 2'd3 && !in_data.four) begin
          data_next.anum = 11'd0;
        end
      end
      FMT_DXT3: data_next.anum = 11'(in_data.a3);
      FMT_DXT5: begin
        if (in_data.acode == 3'd0) begin
          data_next.anum = 11'(in_data.a0);
        end else if (in_data.acode == 3'd1) begin
          data_next.anum = 11'(in_data.a1);
        end else if (in_data.a0 > in_data.a1) begin
          data_next.anum  = wsum;
          data_next.akind = ALPHA_DIV7;
        end else if (in_data.acode < 3'd6) begin
          data_next.anum  = wsum;
          data_next.akind = ALPHA_DIV5;
        end else if (in_data.acode == 3'd6) begin
          data_next.anum = 11'd0;
        end
      end
      default: data_next.anum = 11'(ALPHA_OPAQUE);
    endcase
  end

  // stage register
  assign adv      = !valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== design/dxt_divide.sv =====
// dxt_divide: third pipeline stage, constant division by reciprocal multiply
// depends on dxt_pkg
module dxt_divide
  import dxt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  interp_t in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output texel_t  out_data
);

  logic [19:0] cprod;
  logic [22:0] aprod;
  logic        adv;
  texel_t      data_next;
  logic        valid;
  texel_t      data;

  // colour thirds, then alpha fifths or sevenths, all truncating
  always_comb begin
    cprod = 20'd0;
    for (int ch = 0; ch < 3; ch++) begin
      cprod = 20'(in_data.cnum[ch]) * 20'(RECIP3);
      if (in_data.div3) begin
        data_next.rgb[ch] = cprod[18:11];
      end else begin
        data_next.rgb[ch] = in_data.cnum[ch][7:0];
      end
    end

    case (in_data.akind)
      ALPHA_DIV5: aprod = 23'(in_data.anum) * 23'(RECIP5);
      ALPHA_DIV7: aprod = 23'(in_data.anum) * 23'(RECIP7);
      default:    aprod = 23'd0;
    endcase
    if (in_data.akind == ALPHA_DIV5 || in_data.akind == ALPHA_DIV7) begin
      data_next.a = aprod[21:14];
    end else begin
      data_next.a = in_data.anum[7:0];
    end
  end

  // stage register
  assign adv      = !valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== design/dxt_texel_decoder.sv =====
// dxt_texel_decoder: top level, configuration registers, stage chain and output packing
// depends on dxt_pkg, dxt_unpack, dxt_interp, dxt_divide
//
// Usage: the input channel carries one texel request per accepted cycle
// (in_valid high, in_stall low): the alpha half and colour half of an S3TC
// block plus the texel column and row. The output channel returns one
// pixel_word per request, in order, on out_valid / out_stall.
// From acceptance, a request passes through the unpack, interpolate, divide
// and output packing registers in that order before out_valid. Throughput
// is one texel per cycle while out_stall stays low; each stage holds its
// own valid bit, so bubbles close up and a new request is taken while a
// finished texel waits at the output.
// When the receiver stalls, the output register holds its word and the
// stall reaches in_stall only once every stage ahead is full.
// The configuration port (APB-style, pready always high) holds the block
// format at byte address 0 and the 16-bit output select at address 4; the user
// writes it only while the pipeline is empty, which the block does not enforce.
// Synchronous reset empties every stage and clears both registers to 0
// (DXT1 opaque, ARGB8888 output).
module dxt_texel_decoder
  import dxt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] alpha_block,
  input  logic [63:0] color_block,
  input  logic [1:0]  texel_col,
  input  logic [1:0]  texel_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pixel_word
);

  logic [1:0]  block_format;
  logic        output_16bit;
  logic        s1_valid;
  logic        s1_stall;
  unpack_t     s1_data;
  logic        s2_valid;
  logic        s2_stall;
  interp_t     s2_data;
  logic        s3_valid;
  logic        s3_stall;
  texel_t      s3_data;
  logic [31:0] word_next;
  logic        valid;
  logic [31:0] word;
  logic        adv;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= FMT_DXT1;
      output_16bit <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_FORMAT: block_format <= pwdata[1:0];
        REG_OUT16:  output_16bit <= pwdata[0];
        default:    block_format <= block_format;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FORMAT: prdata = 32'(block_format);
      REG_OUT16:  prdata = 32'(output_16bit);
      default:    prdata = 32'd0;
    endcase
  end

  // pipeline stages
  dxt_unpack u_unpack (
    .clk          (clk),
    .rst          (rst),
    .block_format (block_format),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .alpha_block  (alpha_block),
    .color_block  (color_block),
    .texel_col    (texel_col),
    .texel_row    (texel_row),
    .out_valid    (s1_valid),
    .out_stall    (s1_stall),
    .out_data     (s1_data)
  );

  dxt_interp u_interp (
    .clk          (clk),
    .rst          (rst),
    .block_format (block_format),
    .in_valid     (s1_valid),
    .in_stall     (s1_stall),
    .in_data      (s1_data),
    .out_valid    (s2_valid),
    .out_stall    (s2_stall),
    .out_data     (s2_data)
  );

  dxt_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_stall  (s2_stall),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_stall (s3_stall),
    .out_data  (s3_data)
  );

  // output packing, argb8888 or argb1555 in the low half
  always_comb begin
    if (output_16bit) begin
      word_next = {16'd0, s3_data.a[7], s3_data.rgb[CH_R][7:3],
                   s3_data.rgb[CH_G][7:3], s3_data.rgb[CH_B][7:3]};
    end else begin
      word_next = {s3_data.a, s3_data.rgb[CH_R], s3_data.rgb[CH_G], s3_data.rgb[CH_B]};
    end
  end

  // output register
  assign adv      = !valid || !out_stall;
  assign s3_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid) begin
      word <= word_next;
    end
  end

  assign out_valid  = valid;
  assign pixel_word = word;

  // the input only backs up once the whole chain is full and held
  a_stall_chain: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && s3_valid && out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  // a texel leaving the divide stage lands in the output register
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s3_stall) |=> out_valid)
    else $error("texel from divide stage lost");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid directly after reset");

endmodule

// ===== test/dxt_texel_checker.sv =====
// dxt_texel_checker: watches the request, result and register ports of the texel decoder,
// predicts each pixel word and compares it with what comes out
// depends on dxt_pkg for format codes, register indexes and the opaque alpha value
module dxt_texel_checker
  import dxt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] alpha_block,
  input  logic [63:0] color_block,
  input  logic [1:0]  texel_col,
  input  logic [1:0]  texel_row,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] pixel_word,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_FORMAT = {REG_FORMAT, 2'b00};
  localparam logic [2:0] ADDR_OUT16  = {REG_OUT16, 2'b00};

  // colour codes of a texel
  localparam logic [1:0] CODE_C0    = 2'd0;
  localparam logic [1:0] CODE_C1    = 2'd1;
  localparam logic [1:0] CODE_THIRD = 2'd2;
  localparam logic [1:0] CODE_LAST  = 2'd3;

  // DXT5 alpha codes with a fixed meaning
  localparam logic [2:0] ACODE_A0   = 3'd0;
  localparam logic [2:0] ACODE_A1   = 3'd1;
  localparam logic [2:0] ACODE_ZERO = 3'd6;

  logic [1:0]  format_q = FMT_DXT1;
  bit          pack16_q = 1'b0;
  logic [31:0] expected_pixels[$];
  logic [31:0] wanted_word;
  int          mismatch_count = 0;
  int          pending_count = 0;

  assign mismatches  = mismatch_count;
  assign outstanding = pending_count;

  // rgb565 endpoint widened to 8 bits per channel by replicating top bits
  function automatic logic [23:0] widen_rgb565(logic [15:0] c);
    return {c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
  endfunction

  // one channel of the selected or interpolated colour
  function automatic logic [7:0] blend_channel(int e0, int e1, logic [1:0] code, bit four);
    case (code)
      CODE_C0:    return 8'(e0);
      CODE_C1:    return 8'(e1);
      CODE_THIRD: return four ? 8'((2 * e0 + e1) / 3) : 8'((e0 + e1) / 2);
      default:    return four ? 8'((e0 + 2 * e1) / 3) : 8'd0;
    endcase
  endfunction

  function automatic logic [31:0] decode_texel_word(logic [1:0] fmt, bit pack16,
                                                    logic [63:0] ablk, logic [63:0] cblk,
                                                    logic [1:0] col, logic [1:0] row);
    int          t;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [1:0]  code;
    bit          four;
    logic [23:0] e0;
    logic [23:0] e1;
    logic [23:0] rgb;
    logic [7:0]  alpha;
    logic [3:0]  nib;
    int          a0;
    int          a1;
    int          ac;
    int          blend;
    t = {row, col};
    c0 = cblk[15:0];
    c1 = cblk[31:16];
    code = cblk[32 + 2 * t +: 2];
    four = (fmt == FMT_DXT3) || (fmt == FMT_DXT5) || (c0 > c1);
    e0 = widen_rgb565(c0);
    e1 = widen_rgb565(c1);
    for (int ch = 0; ch < 3; ch++) begin
      rgb[8 * ch +: 8] = blend_channel(e0[8 * ch +: 8], e1[8 * ch +: 8], code, four);
    end
    // alpha rule of the block format
    alpha = ALPHA_OPAQUE;
    case (fmt)
      FMT_PUNCH: begin
        if (code == CODE_LAST && !four) alpha = 8'd0;
      end
      FMT_DXT3: begin
        nib = ablk[4 * t +: 4];
        alpha = {nib, nib};
      end
      FMT_DXT5: begin
        a0 = ablk[7:0];
        a1 = ablk[15:8];
        ac = ablk[16 + 3 * t +: 3];
        if (ac == ACODE_A0) blend = a0;
        else if (ac == ACODE_A1) blend = a1;
        else if (a0 > a1) blend = ((8 - ac) * a0 + (ac - 1) * a1) / 7;
        else if (ac < ACODE_ZERO) blend = ((6 - ac) * a0 + (ac - 1) * a1) / 5;
        else if (ac == ACODE_ZERO) blend = 0;
        else blend = 255;
        alpha = 8'(blend);
      end
      default: ;
    endcase
    if (pack16) return {16'h0000, alpha[7], rgb[23:19], rgb[15:11], rgb[7:3]};
    return {alpha, rgb};
  endfunction

  // register shadow, result comparison and request prediction
  always @(posedge clk) begin
    if (rst) begin
      format_q <= FMT_DXT1;
      pack16_q <= 1'b0;
      expected_pixels.delete();
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_FORMAT: format_q <= pwdata[1:0];
          ADDR_OUT16:  pack16_q <= pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t pixel_word %08h with no request waiting (expected none)",
                   $time, pixel_word);
          mismatch_count <= mismatch_count + 1;
        end else begin
          wanted_word = expected_pixels.pop_front();
          if (pixel_word !== wanted_word) begin
            $display("%0t pixel_word mismatch: expected %08h, actual %08h",
                     $time, wanted_word, pixel_word);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(decode_texel_word(format_q, pack16_q, alpha_block,
                                                    color_block, texel_col, texel_row));
      end
      pending_count <= expected_pixels.size();
    end
  end

endmodule

// ===== test/dxt_texel_decoder_tb.sv =====
// dxt_texel_decoder_tb: drives texel requests and register writes into the decoder
// depends on dxt_pkg, dxt_texel_decoder and dxt_texel_checker, which does the comparing
module dxt_texel_decoder_tb
  import dxt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  ADDR_FORMAT     = {REG_FORMAT, 2'b00};
  localparam logic [2:0]  ADDR_OUT16      = {REG_OUT16, 2'b00};
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          PHASE_REQUESTS  = 110;

  // texel t gets colour code t mod 4, and DXT5 alpha code t mod 8
  localparam logic [31:0] CODES_BY_COL    = 32'hE4E4E4E4;
  localparam logic [47:0] ACODES_BY_TEXEL = 48'hFAC688FAC688;
  localparam logic [63:0] BLK_HI_LO       = {CODES_BY_COL, 16'h001F, 16'hFFE0};
  localparam logic [63:0] BLK_LO_HI       = {CODES_BY_COL, 16'hF800, 16'h07E0};
  localparam logic [63:0] BLK_EQUAL       = {CODES_BY_COL, 16'h8410, 16'h8410};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] alpha_block = '0;
  logic [63:0] color_block = '0;
  logic [1:0]  texel_col = '0;
  logic [1:0]  texel_row = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] pixel_word;
  int          mismatches;
  int          outstanding;
  int          quiet_cycles = 0;
  int          stall_run = 0;
  int          stall_pick;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dxt_texel_decoder uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .alpha_block (alpha_block),
    .color_block (color_block),
    .texel_col   (texel_col),
    .texel_row   (texel_row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_word  (pixel_word)
  );

  dxt_texel_checker texel_check (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .alpha_block (alpha_block),
    .color_block (color_block),
    .texel_col   (texel_col),
    .texel_row   (texel_row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_word  (pixel_word),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // receiver stalls: short random flicker, long quiet stretches, occasional long holds
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_pick = $urandom_range(0, 9);
      if (stall_pick < 2) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(30, 80);
      end else if (stall_pick < 3) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(10, 25);
      end else begin
        out_stall <= 1'($urandom_range(0, 1));
        stall_run = $urandom_range(1, 6);
      end
    end else begin
      stall_run = stall_run - 1;
    end
  end

  // watchdog on cycles with no request and no result accepted
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("dxt_texel_decoder_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one request and hold it until taken
  task automatic send_texel(logic [63:0] ablk, logic [63:0] cblk,
                            logic [1:0] col, logic [1:0] row);
    alpha_block <= ablk;
    color_block <= cblk;
    texel_col   <= col;
    texel_row   <= row;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_for(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // stop sending and wait for every outstanding pixel
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // setup then access cycle, bus left selected for a following write
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [1:0] fmt, bit pack16);
    drain_pipeline();
    write_reg(ADDR_FORMAT, {30'($urandom), fmt});
    write_reg(ADDR_OUT16, {31'($urandom), pack16});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int          phase;
    int          item;
    int          burst_left;
    int          gap;
    logic [1:0]  fmt;
    bit          pack16;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [31:0] codes;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [47:0] acodes;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting: DXT1 opaque, 32-bit words; alpha half must be ignored
    send_texel('0, '0, 2'd0, 2'd0);
    send_texel('1, '1, 2'd3, 2'd3);
    send_texel({$urandom, $urandom}, BLK_HI_LO, 2'd0, 2'd0);
    send_texel({$urandom, $urandom}, BLK_HI_LO, 2'd1, 2'd1);
    send_texel({$urandom, $urandom}, BLK_HI_LO, 2'd2, 2'd2);
    send_texel({$urandom, $urandom}, BLK_HI_LO, 2'd3, 2'd3);
    send_texel('0, BLK_LO_HI, 2'd2, 2'd1);
    send_texel('0, BLK_LO_HI, 2'd3, 2'd1);

    // punch-through: black code gives alpha 0, packed as 1555
    apply_setting(FMT_PUNCH, 1'b1);
    send_texel('1, BLK_LO_HI, 2'd3, 2'd0);
    send_texel('1, BLK_LO_HI, 2'd2, 2'd0);
    send_texel('1, BLK_HI_LO, 2'd3, 2'd2);
    send_texel('1, BLK_EQUAL, 2'd3, 2'd1);

    // explicit alpha nibbles, four-colour mode regardless of endpoint order
    apply_setting(FMT_DXT3, 1'b0);
    send_texel(64'hFEDCBA9876543210, BLK_LO_HI, 2'd3, 2'd3);
    send_texel(64'hFEDCBA9876543210, BLK_LO_HI, 2'd2, 2'd0);
    send_texel(64'h0123456789ABCDEF, BLK_EQUAL, 2'd1, 2'd2);

    // interpolated alpha, eight-step and six-step palettes
    apply_setting(FMT_DXT5, 1'b0);
    send_texel({ACODES_BY_TEXEL, 8'h00, 8'hFF}, BLK_LO_HI, 2'd2, 2'd0);
    send_texel({ACODES_BY_TEXEL, 8'h00, 8'hFF}, BLK_LO_HI, 2'd3, 2'd1);
    send_texel({ACODES_BY_TEXEL, 8'h00, 8'hFF}, BLK_HI_LO, 2'd0, 2'd0);
    send_texel({ACODES_BY_TEXEL, 8'hF0, 8'h10}, BLK_HI_LO, 2'd1, 2'd0);
    send_texel({ACODES_BY_TEXEL, 8'hF0, 8'h10}, BLK_HI_LO, 2'd1, 2'd1);
    send_texel({ACODES_BY_TEXEL, 8'hF0, 8'h10}, BLK_EQUAL, 2'd2, 2'd1);
    send_texel({ACODES_BY_TEXEL, 8'hF0, 8'h10}, BLK_EQUAL, 2'd3, 2'd1);
    send_texel({ACODES_BY_TEXEL, 8'h80, 8'h80}, BLK_LO_HI, 2'd3, 2'd0);

    // 1555 alpha bit taken from bit 7 of the interpolated alpha
    apply_setting(FMT_DXT5, 1'b1);
    send_texel({ACODES_BY_TEXEL, 8'h00, 8'hFF}, BLK_HI_LO, 2'd0, 2'd0);
    send_texel({ACODES_BY_TEXEL, 8'hF0, 8'h10}, BLK_HI_LO, 2'd2, 2'd1);

    // random requests: every format with both word layouts, then random settings
    for (phase = 0; phase < 10; phase++) begin
      if (phase < 8) begin
        fmt = phase[1:0];
        pack16 = phase[2];
      end else begin
        fmt = 2'($urandom_range(0, 3));
        pack16 = 1'($urandom_range(0, 1));
      end
      apply_setting(fmt, pack16);
      burst_left = 0;
      for (item = 0; item < PHASE_REQUESTS; item++) begin
        if (item == PHASE_REQUESTS / 2) drain_pipeline();
        // bursts of random length with random gaps
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          if (gap != 0) idle_for(gap);
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
        end
        burst_left = burst_left - 1;
        // endpoint ordering drives the three- or four-colour choice
        c0 = 16'($urandom);
        c1 = 16'($urandom);
        codes = $urandom;
        case ($urandom_range(0, 7))
          0, 1: begin
            c0[15] = 1'b1;
            c1[15] = 1'b0;
          end
          2, 3: begin
            c0[15] = 1'b0;
            c1[15] = 1'b1;
          end
          4: c1 = c0;
          5: begin
            c0 = '1;
            c1 = '0;
          end
          6: begin
            c0 = '0;
            c1 = '1;
          end
          default: ;
        endcase
        // alpha endpoint ordering picks the DXT5 palette
        a0 = 8'($urandom);
        a1 = 8'($urandom);
        acodes = {16'($urandom), $urandom};
        case ($urandom_range(0, 4))
          0, 1: begin
            a0[7] = 1'b1;
            a1[7] = 1'b0;
          end
          2: begin
            a0[7] = 1'b0;
            a1[7] = 1'b1;
          end
          3: a1 = a0;
          default: ;
        endcase
        send_texel({acodes, a1, a0}, {codes, c1, c0},
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      end
    end

    drain_pipeline();
    repeat (8) @(negedge clk);
    if (outstanding != 0) begin
      $display("%0t %0d pixel words never arrived", $time, outstanding);
    end
    if (mismatches == 0 && outstanding == 0) begin
      $display("dxt_texel_decoder_tb: clean");
    end else begin
      $display("dxt_texel_decoder_tb: errors");
    end
    $finish;
  end

endmodule
